// File: rtl/core/multi_timer_table_macros.svh
// assertion macros for the timer table
`ifndef MULTI_TIMER_TABLE_MACROS_SVH
`define MULTI_TIMER_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define MTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer table check failed");
`define MTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer table check failed");
`else
`define MTT_ASSERT_NOW(label, ante, cons)
`define MTT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/mtt_pkg.sv
package mtt_pkg;

  localparam int TIMER_COUNT = 16;
  localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);
  localparam logic [31:0] NO_DEADLINE = 32'hffff_ffff;

  localparam logic [2:0] FUNC_ALLOC   = 3'd0;
  localparam logic [2:0] FUNC_FREE    = 3'd1;
  localparam logic [2:0] FUNC_INIT    = 3'd2;
  localparam logic [2:0] FUNC_SETTIME = 3'd3;
  localparam logic [2:0] FUNC_TICK    = 3'd4;

  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_EXPIRY = 2'd1;
  localparam logic [1:0] KIND_TASK   = 2'd2;

  localparam logic [1:0] ENT_FREE  = 2'd0;
  localparam logic [1:0] ENT_ALLOC = 2'd1;
  localparam logic [1:0] ENT_ARMED = 2'd2;

  localparam logic CFG_TASK_INDEX  = 1'b0;
  localparam logic CFG_TASK_ENABLE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH,
    ST_TASK
  } state_t;

  typedef struct packed {
    logic cmd;
    logic issue;
    logic alloc_step;
    logic flush;
    logic task_out;
  } ctrl_t;

endpackage

// File: rtl/core/mtt_ram.sv
module mtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/multi_timer_table.sv
// channel   direction  transfer when        fields
// command   in         start & !busy        func timer_index timeout_ticks dest_queue data_byte
// result    out        strobe (one cycle)   kind entry_index alloc_ok msg_queue msg_byte last
// config    in         cfg_we               cfg_index cfg_data
//
// free, init, settime and a tick that misses the earliest deadline finish in idle, busy stays low
// alloc walks the status flops one entry a cycle, busy until it finds a free entry or passes the last
// a tick that reaches the earliest deadline reads the entry memories one entry a cycle, then stays
//   busy through the drain and flush states, and the task state when a task switch follows a message
// reset clears the status flops, tick count, earliest deadline and config; memories are not cleared
// results cannot be held off; each strobe is a transfer
`include "multi_timer_table_macros.svh"

module multi_timer_table
  import mtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [3:0]  timer_index,
  input  logic [31:0] timeout_ticks,
  input  logic [2:0]  dest_queue,
  input  logic [7:0]  data_byte,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [3:0]  entry_index,
  output logic        alloc_ok,
  output logic [2:0]  msg_queue,
  output logic [7:0]  msg_byte,
  output logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  state_t state, state_next;
  ctrl_t  ctrl;

  logic [31:0]      tick_count;
  logic [31:0]      earliest;
  logic [1:0]       status [TIMER_COUNT];
  logic [IDX_W-1:0] scan_idx;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic             task_hit;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;
  logic [2:0]       pend_queue;
  logic [7:0]       pend_byte;
  logic [3:0]       task_index;
  logic             task_enable;

  logic             accept;
  logic             in_range;
  logic [IDX_W-1:0] cmd_idx;
  logic [31:0]      tick_inc;
  logic [31:0]      settime_dl;
  logic [31:0]      cmp_a, cmp_b;
  logic             cmp_gt;
  logic [31:0]      dl_rdata;
  logic [10:0]      msg_rdata;
  logic             dl_we, msg_we;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && (state == ST_IDLE);
  assign in_range = int'(timer_index) < TIMER_COUNT;
  assign cmd_idx  = IDX_W'(timer_index);
  assign tick_inc   = tick_count + 32'd1;
  assign settime_dl = timeout_ticks + tick_count;

  // shared compare: deadline checks in idle, expiry check while scanning
  always_comb begin
    if (state == ST_IDLE) begin
      cmp_a = earliest;
      cmp_b = (func == FUNC_TICK) ? tick_inc : settime_dl;
    end else begin
      cmp_a = dl_rdata;
      cmp_b = tick_count;
    end
  end
  assign cmp_gt = cmp_a > cmp_b;

  assign dl_we  = ctrl.cmd && (func == FUNC_SETTIME) && in_range;
  assign msg_we = ctrl.cmd && (func == FUNC_INIT) && in_range;

  mtt_ram #(.WIDTH(32), .DEPTH(TIMER_COUNT)) u_deadline_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (cmd_idx),
    .wdata (settime_dl),
    .raddr (scan_idx),
    .rdata (dl_rdata)
  );

  mtt_ram #(.WIDTH(11), .DEPTH(TIMER_COUNT)) u_message_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (cmd_idx),
    .wdata ({dest_queue, data_byte}),
    .raddr (scan_idx),
    .rdata (msg_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (func == FUNC_ALLOC)) begin
          state_next = ST_ALLOC;
        end else if (accept && (func == FUNC_TICK) && !cmp_gt) begin
          state_next = ST_SCAN;
        end
      end
      ST_ALLOC: begin
        if ((status[scan_idx] == ENT_FREE) || (scan_idx == LAST_IDX)) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FLUSH;
      ST_FLUSH: state_next = (pend_valid && task_hit) ? ST_TASK : ST_IDLE;
      ST_TASK:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE:  ctrl.cmd = accept;
      ST_ALLOC: ctrl.alloc_step = 1'b1;
      ST_SCAN:  ctrl.issue = 1'b1;
      ST_FLUSH: ctrl.flush = 1'b1;
      ST_TASK:  ctrl.task_out = 1'b1;
      default:  ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      earliest    <= NO_DEADLINE;
      status      <= '{default: ENT_FREE};
      scan_idx    <= '0;
      rd_valid    <= 1'b0;
      task_hit    <= 1'b0;
      pend_valid  <= 1'b0;
      strobe      <= 1'b0;
      task_index  <= '0;
      task_enable <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      rd_valid <= ctrl.issue;

      if (cfg_we) begin
        case (cfg_index)
          CFG_TASK_INDEX:  task_index  <= cfg_data;
          CFG_TASK_ENABLE: task_enable <= cfg_data[0];
          default: ;
        endcase
      end

      if (ctrl.issue || ctrl.alloc_step) begin
        scan_idx <= scan_idx + 1'b1;
      end else if (state == ST_IDLE) begin
        scan_idx <= '0;
      end
      if (ctrl.issue) begin
        rd_idx <= scan_idx;
      end

      if (ctrl.cmd) begin
        case (func)
          FUNC_FREE: begin
            if (in_range) begin
              status[cmd_idx] <= ENT_FREE;
            end
          end
          FUNC_SETTIME: begin
            if (in_range) begin
              status[cmd_idx] <= ENT_ARMED;
              if (cmp_gt) begin
                earliest <= settime_dl;
              end
            end
          end
          FUNC_TICK: begin
            tick_count <= tick_inc;
            if (!cmp_gt) begin
              earliest   <= NO_DEADLINE;
              task_hit   <= 1'b0;
              pend_valid <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (ctrl.alloc_step) begin
        if (status[scan_idx] == ENT_FREE) begin
          status[scan_idx] <= ENT_ALLOC;
          strobe      <= 1'b1;
          kind        <= KIND_ALLOC;
          entry_index <= 4'(scan_idx);
          alloc_ok    <= 1'b1;
          msg_queue   <= '0;
          msg_byte    <= '0;
          last        <= 1'b1;
        end else if (scan_idx == LAST_IDX) begin
          strobe      <= 1'b1;
          kind        <= KIND_ALLOC;
          entry_index <= '0;
          alloc_ok    <= 1'b0;
          msg_queue   <= '0;
          msg_byte    <= '0;
          last        <= 1'b1;
        end
      end

      // entry read last cycle: expire it or fold it into the earliest deadline
      if (rd_valid && (status[rd_idx] == ENT_ARMED)) begin
        if (!cmp_gt) begin
          status[rd_idx] <= ENT_ALLOC;
          if (task_enable && (int'(rd_idx) == int'(task_index))) begin
            task_hit <= 1'b1;
          end else begin
            if (pend_valid) begin
              strobe      <= 1'b1;
              kind        <= KIND_EXPIRY;
              entry_index <= 4'(pend_idx);
              alloc_ok    <= 1'b0;
              msg_queue   <= pend_queue;
              msg_byte    <= pend_byte;
              last        <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_idx   <= rd_idx;
            pend_queue <= msg_rdata[10:8];
            pend_byte  <= msg_rdata[7:0];
          end
        end else if (earliest > dl_rdata) begin
          earliest <= dl_rdata;
        end
      end

      if (ctrl.flush) begin
        if (pend_valid) begin
          strobe      <= 1'b1;
          kind        <= KIND_EXPIRY;
          entry_index <= 4'(pend_idx);
          alloc_ok    <= 1'b0;
          msg_queue   <= pend_queue;
          msg_byte    <= pend_byte;
          last        <= !task_hit;
        end else if (task_hit) begin
          strobe      <= 1'b1;
          kind        <= KIND_TASK;
          entry_index <= task_index;
          alloc_ok    <= 1'b0;
          msg_queue   <= '0;
          msg_byte    <= '0;
          last        <= 1'b1;
        end
      end

      if (ctrl.task_out) begin
        strobe      <= 1'b1;
        kind        <= KIND_TASK;
        entry_index <= task_index;
        alloc_ok    <= 1'b0;
        msg_queue   <= '0;
        msg_byte    <= '0;
        last        <= 1'b1;
      end
    end
  end

  `MTT_ASSERT_NOW(a_last_ends_work, strobe && last, state == ST_IDLE)
  `MTT_ASSERT_NOW(a_more_follows, strobe && !last, busy)
  `MTT_ASSERT_NEXT(a_alloc_goes_busy, start && !busy && (func == FUNC_ALLOC), busy)

endmodule

// File: verif/mtt_checker.sv
module mtt_checker
  import mtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  func,
  input  logic [3:0]  timer_index,
  input  logic [31:0] timeout_ticks,
  input  logic [2:0]  dest_queue,
  input  logic [7:0]  data_byte,
  input  logic        strobe,
  input  logic [1:0]  kind,
  input  logic [3:0]  entry_index,
  input  logic        alloc_ok,
  input  logic [2:0]  msg_queue,
  input  logic [7:0]  msg_byte,
  input  logic        last,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  output int          fail_count,
  output int          owed_count,
  output int          result_count
);

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] idx;
    logic       ok;
    logic [2:0] q;
    logic [7:0] b;
    logic       last;
  } timer_result_t;

  timer_result_t owed_results[$];

  logic [31:0] tick_now;
  logic [31:0] soonest;
  logic [1:0]  status   [TIMER_COUNT];
  logic [31:0] deadline [TIMER_COUNT];
  logic [2:0]  queue_of [TIMER_COUNT];
  logic [7:0]  byte_of  [TIMER_COUNT];
  logic [3:0]  task_idx;
  logic        task_en;

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic run_timer_command(input logic [2:0] f, input logic [3:0] idx,
                                   input logic [31:0] to, input logic [2:0] q,
                                   input logic [7:0] b);
    timer_result_t r;
    bit found;
    bit switch_due;
    int first_new;
    int i;
    logic [31:0] dl;
    first_new = owed_results.size();
    case (f)
      FUNC_ALLOC: begin
        r = '0;
        r.kind = KIND_ALLOC;
        found = 0;
        for (i = 0; i < TIMER_COUNT; i++) begin
          if (!found && status[i] == ENT_FREE) begin
            status[i] = ENT_ALLOC;
            r.idx = 4'(i);
            r.ok = 1'b1;
            found = 1;
          end
        end
        owed_results.push_back(r);
      end
      FUNC_FREE: begin
        if (int'(idx) < TIMER_COUNT) status[idx] = ENT_FREE;
      end
      FUNC_INIT: begin
        if (int'(idx) < TIMER_COUNT) begin
          queue_of[idx] = q;
          byte_of[idx] = b;
        end
      end
      FUNC_SETTIME: begin
        if (int'(idx) < TIMER_COUNT) begin
          dl = to + tick_now;
          deadline[idx] = dl;
          status[idx] = ENT_ARMED;
          if (soonest > dl) soonest = dl;
        end
      end
      FUNC_TICK: begin
        tick_now = tick_now + 32'd1;
        if (soonest <= tick_now) begin
          soonest = NO_DEADLINE;
          switch_due = 0;
          for (i = 0; i < TIMER_COUNT; i++) begin
            if (status[i] == ENT_ARMED) begin
              if (deadline[i] <= tick_now) begin
                status[i] = ENT_ALLOC;
                if (task_en && i == int'(task_idx)) begin
                  switch_due = 1;
                end else begin
                  r = '0;
                  r.kind = KIND_EXPIRY;
                  r.idx = 4'(i);
                  r.q = queue_of[i];
                  r.b = byte_of[i];
                  owed_results.push_back(r);
                end
              end else if (soonest > deadline[i]) begin
                soonest = deadline[i];
              end
            end
          end
          if (switch_due) begin
            r = '0;
            r.kind = KIND_TASK;
            r.idx = task_idx;
            owed_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
    if (owed_results.size() > first_new) begin
      r = owed_results.pop_back();
      r.last = 1'b1;
      owed_results.push_back(r);
    end
  endtask

  always @(posedge clk) begin : watch
    timer_result_t want;
    int i;
    if (rst) begin
      fail_count = 0;
      result_count = 0;
      tick_now = '0;
      soonest = NO_DEADLINE;
      task_idx = '0;
      task_en = 1'b0;
      for (i = 0; i < TIMER_COUNT; i++) begin
        status[i] = ENT_FREE;
        deadline[i] = '0;
        queue_of[i] = '0;
        byte_of[i] = '0;
      end
      owed_results.delete();
    end else begin
      if (strobe) begin
        result_count++;
        if (owed_results.size() == 0) begin
          $error("result transfer with nothing owed: kind %0d entry %0d", kind, entry_index);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("kind", want.kind, kind);
          check_field("entry_index", want.idx, entry_index);
          check_field("alloc_ok", want.ok, alloc_ok);
          check_field("msg_queue", want.q, msg_queue);
          check_field("msg_byte", want.b, msg_byte);
          check_field("last", want.last, last);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_TASK_INDEX) task_idx = cfg_data;
        else task_en = cfg_data[0];
      end
      if (start && !busy)
        run_timer_command(func, timer_index, timeout_ticks, dest_queue, data_byte);
    end
    owed_count = owed_results.size();
  end

endmodule

// File: verif/tb_multi_timer_table.sv
module tb_multi_timer_table;
  import mtt_pkg::*;

  localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;
  localparam int SETTLE_CYCLES = TIMER_COUNT + 8;
  localparam int PHASES = 5;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic [2:0]  func;
  logic [3:0]  timer_index;
  logic [31:0] timeout_ticks;
  logic [2:0]  dest_queue;
  logic [7:0]  data_byte;
  logic        cfg_we;
  logic        cfg_index;
  logic [3:0]  cfg_data;
  logic        busy;
  logic        strobe;
  logic [1:0]  kind;
  logic [3:0]  entry_index;
  logic        alloc_ok;
  logic [2:0]  msg_queue;
  logic [7:0]  msg_byte;
  logic        last;
  int          fail_count;
  int          owed_count;
  int          result_count;

  logic [TIMER_COUNT-1:0] has_msg;
  int  sent_count;
  bit  steady;

  always #2 clk = ~clk;

  multi_timer_table uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .timer_index(timer_index), .timeout_ticks(timeout_ticks),
    .dest_queue(dest_queue), .data_byte(data_byte),
    .strobe(strobe), .kind(kind), .entry_index(entry_index), .alloc_ok(alloc_ok),
    .msg_queue(msg_queue), .msg_byte(msg_byte), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mtt_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .timer_index(timer_index), .timeout_ticks(timeout_ticks),
    .dest_queue(dest_queue), .data_byte(data_byte),
    .strobe(strobe), .kind(kind), .entry_index(entry_index), .alloc_ok(alloc_ok),
    .msg_queue(msg_queue), .msg_byte(msg_byte), .last(last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .owed_count(owed_count), .result_count(result_count)
  );

  task automatic issue(input logic [2:0] f, input logic [3:0] idx, input logic [31:0] to,
                       input logic [2:0] q, input logic [7:0] b);
    int gap;
    start <= 1'b1;
    func <= f;
    timer_index <= idx;
    timeout_ticks <= to;
    dest_queue <= q;
    data_byte <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
    if (f == FUNC_INIT) has_msg[idx] = 1'b1;
    if ($urandom_range(0, 19) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all owed results, then let a silent scan finish
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    wait (owed_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_task_timer(input logic [3:0] idx, input logic en);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TASK_INDEX;
    cfg_data <= idx;
    @(posedge clk);
    cfg_index <= CFG_TASK_ENABLE;
    cfg_data <= {3'b000, en};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_timeout();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 8);
    if (sel < 8) return $urandom_range(0, 40);
    if (sel == 8) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'h8000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic random_command(input int alloc_pct, input logic [3:0] focus);
    int sel;
    logic [3:0] idx;
    sel = $urandom_range(0, 99);
    idx = ($urandom_range(0, 3) == 0) ? focus : 4'($urandom_range(0, TIMER_COUNT - 1));
    if (sel < alloc_pct) begin
      issue(FUNC_ALLOC, 4'($urandom()), $urandom(), 3'($urandom()), 8'($urandom()));
    end else if (sel < alloc_pct + 8) begin
      issue(FUNC_FREE, idx, $urandom(), 3'($urandom()), 8'($urandom()));
    end else if (sel < alloc_pct + 22 || (sel < alloc_pct + 46 && !has_msg[idx])) begin
      // an entry is always given its message before it can be armed
      issue(FUNC_INIT, idx, $urandom(), 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    end else if (sel < alloc_pct + 46) begin
      issue(FUNC_SETTIME, idx, pick_timeout(), 3'($urandom()), 8'($urandom()));
    end else if (sel < 96) begin
      issue(FUNC_TICK, 4'($urandom()), $urandom(), 3'($urandom()), 8'($urandom()));
    end else begin
      issue(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)), 4'($urandom()),
            $urandom(), 3'($urandom()), 8'($urandom()));
    end
  endtask

  initial begin
    logic [3:0] phase_idx [PHASES];
    logic       phase_en  [PHASES];
    int         phase_alloc [PHASES];
    int p;
    int n;
    phase_idx = '{4'd3, 4'd0, 4'd15, 4'd9, 4'd0};
    phase_en = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    phase_alloc = '{18, 40, 18, 18, 18};
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_ALLOC;
    timer_index = '0;
    timeout_ticks = '0;
    dest_queue = '0;
    data_byte = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TASK_INDEX;
    cfg_data = '0;
    has_msg = '0;
    sent_count = 0;
    steady = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_task_timer(4'd15, 1'b1);
    issue(FUNC_ALLOC, 4'd0, 32'd0, 3'd0, 8'd0);
    issue(FUNC_ALLOC, 4'd0, 32'd0, 3'd0, 8'd0);
    issue(FUNC_INIT, 4'd0, 32'd0, 3'd7, 8'd255);
    issue(FUNC_INIT, 4'd1, 32'd0, 3'd0, 8'd0);
    issue(FUNC_INIT, 4'd15, 32'd0, 3'd5, 8'h5a);
    // zero timeout: expires on the next tick
    issue(FUNC_SETTIME, 4'd0, 32'd0, 3'd0, 8'd0);
    issue(FUNC_TICK, 4'd0, 32'd0, 3'd0, 8'd0);
    // messages followed by a task switch, one deadline wrapped past zero
    issue(FUNC_SETTIME, 4'd0, 32'd1, 3'd0, 8'd0);
    issue(FUNC_SETTIME, 4'd15, 32'd1, 3'd0, 8'd0);
    issue(FUNC_SETTIME, 4'd1, 32'hffff_ffff, 3'd0, 8'd0);
    issue(FUNC_TICK, 4'd0, 32'd0, 3'd0, 8'd0);
    // tick short of the deadline, then a scan after the armed entry was freed
    issue(FUNC_SETTIME, 4'd1, 32'd3, 3'd0, 8'd0);
    issue(FUNC_TICK, 4'd0, 32'd0, 3'd0, 8'd0);
    issue(FUNC_FREE, 4'd1, 32'd0, 3'd0, 8'd0);
    issue(FUNC_TICK, 4'd0, 32'd0, 3'd0, 8'd0);
    issue(FUNC_TICK, 4'd0, 32'd0, 3'd0, 8'd0);
    issue(FUNC_SPARE_FIRST, 4'd15, 32'hffff_ffff, 3'd7, 8'd255);
    issue(FUNC_SPARE_LAST, 4'd0, 32'd0, 3'd0, 8'd0);
    issue(FUNC_FREE, 4'd0, 32'd0, 3'd0, 8'd0);
    issue(FUNC_ALLOC, 4'd0, 32'd0, 3'd0, 8'd0);
    issue(FUNC_SETTIME, 4'd0, 32'h8000_0000, 3'd0, 8'd0);
    issue(FUNC_FREE, 4'd0, 32'd0, 3'd0, 8'd0);
    issue(FUNC_SETTIME, 4'd15, 32'd0, 3'd0, 8'd0);
    issue(FUNC_TICK, 4'd0, 32'd0, 3'd0, 8'd0);
    settle();

    for (p = 0; p < PHASES; p++) begin
      set_task_timer(phase_idx[p], phase_en[p]);
      for (n = 0; n < 62; n++) random_command(phase_alloc[p], phase_idx[p]);
      settle();
    end

    $display("%0d commands over %0d task timer settings, %0d results checked",
             sent_count, PHASES + 1, result_count);
    if (fail_count == 0 && owed_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule
